[hdl/mfi_pkg.sv]
// Shared constants and types for the Fermat modular inverse core.
`default_nettype none

package mfi_pkg;

  // Residue width and the prime modulus
  localparam int unsigned WORD_W   = 30;
  localparam int unsigned EXP_BITS = 30;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t MODULUS  = 30'd1000000007;
  localparam word_t EXPONENT = 30'd1000000005;   // modulus minus two
  localparam word_t ONE      = 30'd1;

  // Barrett reduction: mu = floor(2^60 / P), fits in 31 bits
  localparam logic [63:0] MU_FULL    = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

  // Correction limits for the Barrett remainder, which stays below 3P
  localparam logic [31:0] MOD_32   = 32'd1000000007;
  localparam logic [31:0] TWO_P_32 = 32'd2000000014;

  // Pipeline depth of one modular multiplier
  localparam int unsigned MM_LAT = 4;

endpackage

`default_nettype wire

[hdl/mfi_mulmod.sv]
// Four-stage pipelined modular multiplier, Barrett reduction modulo the prime.
`default_nettype none

module mfi_mulmod (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire mfi_pkg::word_t a,
  input  wire mfi_pkg::word_t b,
  output mfi_pkg::word_t      p
);

  logic [59:0] prod;
  logic [61:0] q_full;
  logic [30:0] quot;
  logic [31:0] x_lo;
  logic [31:0] qp;
  logic [31:0] rem;
  logic [31:0] rem_fix;

  // Barrett quotient estimate from the top 31 bits of the product
  always_comb begin
    q_full = 62'(prod[59:29]) * 62'(mfi_pkg::BARRETT_MU);
  end

  // Only the low 32 bits of q*P matter, the remainder is below 3P
  always_comb begin
    qp = 32'(quot) * mfi_pkg::MOD_32;
  end

  // Final correction: at most two subtractions of P
  always_comb begin
    priority if (rem >= mfi_pkg::TWO_P_32) begin
      rem_fix = rem - mfi_pkg::TWO_P_32;
    end else if (rem >= mfi_pkg::MOD_32) begin
      rem_fix = rem - mfi_pkg::MOD_32;
    end else begin
      rem_fix = rem;
    end
  end

  // Stage registers, all frozen together on a stall
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 60'(a) * 60'(b);
      quot <= q_full[61:31];
      x_lo <= prod[31:0];
      rem  <= x_lo - qp;
      p    <= rem_fix[mfi_pkg::WORD_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hdl/mfi_cell.sv]
// One exponent-bit cell: squares the running power, multiplies on a set bit.
`default_nettype none

module mfi_cell #(
  parameter bit EXP_BIT = 1'b1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire mfi_pkg::word_t in_acc,
  input  wire mfi_pkg::word_t in_base,
  output logic                out_valid,
  output mfi_pkg::word_t      out_acc,
  output mfi_pkg::word_t      out_base
);

  logic [mfi_pkg::MM_LAT-1:0] vld;

  // Valid bits run alongside the multiplier stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[mfi_pkg::MM_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[mfi_pkg::MM_LAT-1];

  // Running power squared every cell
  mfi_mulmod u_sq (
    .clk (clk),
    .en  (en),
    .a   (in_base),
    .b   (in_base),
    .p   (out_base)
  );

  // Accumulator: multiply on a set exponent bit, otherwise matched delay
  if (EXP_BIT) begin : g_mul
    mfi_mulmod u_mul (
      .clk (clk),
      .en  (en),
      .a   (in_acc),
      .b   (in_base),
      .p   (out_acc)
    );
  end else begin : g_dly
    mfi_pkg::word_t acc_dly [mfi_pkg::MM_LAT];

    always_ff @(posedge clk) begin
      if (en) begin
        acc_dly[0] <= in_acc;
        for (int i = 1; i < int'(mfi_pkg::MM_LAT); i++) begin
          acc_dly[i] <= acc_dly[i-1];
        end
      end
    end

    assign out_acc = acc_dly[mfi_pkg::MM_LAT-1];
  end

endmodule

`default_nettype wire

[hdl/modular_inverse_fermat_core.sv]
// Top level: inverse modulo 1000000007 by a chain of square-and-multiply cells.
//
//  channel   dir  word fields (low bit up)        handshake
//  s_axis    in   value [29:0], zero pad [31:30]   tvalid / tready
//  m_axis    out  inverse [29:0], zero pad [31:30] tvalid / tready
//
// Accepts one word per cycle while the skid register is empty; each word passes
// one input register, 30 cells of four stages (the depth of one modular
// multiplier) and one output register. Reset clears only the valid bits.
// A word that comes out of the chain behind a stalled output word parks in a
// skid register; while it is full the whole chain holds and s_axis_tready is low.
`default_nettype none

module modular_inverse_fermat_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // value [29:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // inverse [29:0]
);

  localparam int unsigned NCELL = mfi_pkg::EXP_BITS;

  logic           en;
  logic           in_valid;
  mfi_pkg::word_t in_base;
  mfi_pkg::word_t value;

  logic           cv    [NCELL+1];
  mfi_pkg::word_t cacc  [NCELL+1];
  mfi_pkg::word_t cbase [NCELL+1];

  logic           out_valid;
  mfi_pkg::word_t out_data;
  logic           skid_valid;
  mfi_pkg::word_t skid_data;

  // Chain advances whenever the skid register is free
  assign en            = !skid_valid;
  assign s_axis_tready = en;
  assign value         = s_axis_tdata[mfi_pkg::WORD_W-1:0];

  // Input register with one conditional subtraction of the modulus
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (en) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_base <= (value >= mfi_pkg::MODULUS) ? value - mfi_pkg::MODULUS : value;
    end
  end

  assign cv[0]    = in_valid;
  assign cacc[0]  = mfi_pkg::ONE;
  assign cbase[0] = in_base;

  // One cell per exponent bit, lowest bit first
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    mfi_cell #(
      .EXP_BIT (mfi_pkg::EXPONENT[g])
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cv[g]),
      .in_acc    (cacc[g]),
      .in_base   (cbase[g]),
      .out_valid (cv[g+1]),
      .out_acc   (cacc[g+1]),
      .out_base  (cbase[g+1])
    );
  end

  // Output register and skid stage: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (skid_valid) begin
        if (m_axis_tready) begin
          skid_valid <= 1'b0;
        end
      end else if (out_valid && !m_axis_tready) begin
        if (cv[NCELL]) begin
          skid_valid <= 1'b1;
        end
      end else begin
        out_valid <= cv[NCELL];
      end
    end
  end

  // Output register and skid stage: data
  always_ff @(posedge clk) begin
    priority if (skid_valid) begin
      if (m_axis_tready) begin
        out_data <= skid_data;
      end
    end else if (out_valid && !m_axis_tready) begin
      skid_data <= cacc[NCELL];
    end else begin
      out_data <= cacc[NCELL];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_data};

endmodule

`default_nettype wire
